[rtl/imups_pkg.sv]
// ============================================================================
// imups_pkg: shared types for the IMU state propagation block
// Request and result payload structs, the reset gravity value and the pipeline depth.
// ============================================================================
`default_nettype none

package imups_pkg;

    // Gravity magnitude after reset, Q5.16 m/s^2
    localparam logic [20:0] GRAVITY_RESET = 21'd642908;

    // Pipeline depth from accepted request to result strobe
    localparam int unsigned LATENCY = 4;

    typedef struct packed {
        logic [63:0] start_orientation;
        logic [62:0] start_position;
        logic [62:0] start_velocity;
        logic [19:0] time_step;
        logic [62:0] delta_position;
        logic [62:0] delta_velocity;
        logic [63:0] delta_rotation;
    } req_t;

    typedef struct packed {
        logic [63:0] new_orientation;
        logic [62:0] new_position;
        logic [62:0] new_velocity;
        logic        saturated;
    } rsp_t;

endpackage

`default_nettype wire

[rtl/imu_preintegrated_state_propagate.sv]
// ============================================================================
// imu_preintegrated_state_propagate: IMU preintegration state prediction
// Orientation q*gamma, position p+v*dt-g*dt^2/2+R(q)*alpha and velocity
// v-g*dt+R(q)*beta, in fixed point with per-lane saturation.
// ============================================================================
//  channel   signals                     transfer
//  --------  --------------------------  -------------------------------
//  request   start, busy, request        edge with start high, busy low
//  result    done, result                edge ending the cycle done is high
//  config    cfg_we, cfg_wdata           edge with cfg_we high
//
//  One request per cycle; each result is registered in step with its done.
//  Latency is set by the four register stages: products, matrix and
//  gravity terms, rotation products, final sums with rounding and clipping.
//  busy stays low: nothing stalls, since the receiver cannot hold results.
//  Reset clears the stage valid bits and loads the reset gravity value.
// ============================================================================
`default_nettype none

module imu_preintegrated_state_propagate
    import imups_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire req_t        request,
    output logic             done,
    output rsp_t             result,
    input  wire logic        cfg_we,
    input  wire logic [20:0] cfg_wdata
);

    // ------------------------------------------------------------------
    // Helpers: round half up and clip
    // ------------------------------------------------------------------
    function automatic logic [21:0] round_vec(input logic signed [59:0] s);
        logic signed [59:0] b;
        logic signed [31:0] t;
        b = s + 60'sd134217728;
        t = 32'(b >>> 28);
        if (t > 32'sd1048575)
            return {1'b1, 21'h0FFFFF};
        else if (t < -32'sd1048576)
            return {1'b1, 21'h100000};
        else
            return {1'b0, t[20:0]};
    endfunction

    function automatic logic [16:0] round_quat(input logic signed [33:0] s);
        logic signed [33:0] b;
        logic signed [19:0] t;
        b = s + 34'sd8192;
        t = 20'(b >>> 14);
        if (t > 20'sd32767)
            return {1'b1, 16'h7FFF};
        else if (t < -20'sd32768)
            return {1'b1, 16'h8000};
        else
            return {1'b0, t[15:0]};
    endfunction

    logic        accept;
    logic [20:0] gravity_reg;
    logic        v1_reg, v2_reg, v3_reg, done_reg;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Hold the gravity register; the user must write it only while idle, the block does not enforce this
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            gravity_reg <= GRAVITY_RESET;
        else if (cfg_we)
            gravity_reg <= cfg_wdata;
    end

    // Advance the valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= accept;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: unpack lanes, form the 16-bit quaternion products and the v*dt and g*dt products
    // ------------------------------------------------------------------
    logic signed [15:0] q_in [4];
    logic signed [15:0] g_in [4];
    logic signed [20:0] p_in [3], vel_in [3], al_in [3], be_in [3];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            q_in[i] = $signed(request.start_orientation[48 - 16 * i +: 16]);
            g_in[i] = $signed(request.delta_rotation[48 - 16 * i +: 16]);
        end
        for (int i = 0; i < 3; i++)
        begin
            p_in[i]   = $signed(request.start_position[21 * i +: 21]);
            vel_in[i] = $signed(request.start_velocity[21 * i +: 21]);
            al_in[i]  = $signed(request.delta_position[21 * i +: 21]);
            be_in[i]  = $signed(request.delta_velocity[21 * i +: 21]);
        end
    end

    logic signed [31:0] qp1_reg [4][4];
    logic signed [31:0] xx1_reg, yy1_reg, zz1_reg, xy1_reg, xz1_reg, yz1_reg;
    logic signed [31:0] wx1_reg, wy1_reg, wz1_reg;
    logic signed [41:0] vdt1_reg [3];
    logic        [40:0] gdt1_reg;
    logic        [19:0] dt1_reg;
    logic signed [20:0] p1_reg [3], vel1_reg [3], al1_reg [3], be1_reg [3];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j++)
                qp1_reg[i][j] <= q_in[i] * g_in[j];
        xx1_reg <= q_in[1] * q_in[1];
        yy1_reg <= q_in[2] * q_in[2];
        zz1_reg <= q_in[3] * q_in[3];
        xy1_reg <= q_in[1] * q_in[2];
        xz1_reg <= q_in[1] * q_in[3];
        yz1_reg <= q_in[2] * q_in[3];
        wx1_reg <= q_in[0] * q_in[1];
        wy1_reg <= q_in[0] * q_in[2];
        wz1_reg <= q_in[0] * q_in[3];
        for (int i = 0; i < 3; i++)
        begin
            vdt1_reg[i] <= 42'(vel_in[i]) * 42'($signed({1'b0, request.time_step}));
            p1_reg[i]   <= p_in[i];
            vel1_reg[i] <= vel_in[i];
            al1_reg[i]  <= al_in[i];
            be1_reg[i]  <= be_in[i];
        end
        gdt1_reg <= 41'(gravity_reg) * 41'(request.time_step);
        dt1_reg  <= request.time_step;
    end

    // ------------------------------------------------------------------
    // Stage 2: quaternion product lanes, rotation matrix, g*dt^2/2
    // ------------------------------------------------------------------
    logic signed [33:0] acc [4];
    logic        [16:0] oq [4];
    logic signed [33:0] r_next [3][3];
    logic        [60:0] gdtdt;
    logic        [50:0] gdt2_next;

    function automatic logic signed [33:0] ext(input logic signed [31:0] a);
        return 34'(a);
    endfunction

    always_comb
    begin
        acc[0] = ext(qp1_reg[0][0]) - ext(qp1_reg[1][1])
               - ext(qp1_reg[2][2]) - ext(qp1_reg[3][3]);
        acc[1] = ext(qp1_reg[0][1]) + ext(qp1_reg[1][0])
               + ext(qp1_reg[2][3]) - ext(qp1_reg[3][2]);
        acc[2] = ext(qp1_reg[0][2]) - ext(qp1_reg[1][3])
               + ext(qp1_reg[2][0]) + ext(qp1_reg[3][1]);
        acc[3] = ext(qp1_reg[0][3]) + ext(qp1_reg[1][2])
               - ext(qp1_reg[2][1]) + ext(qp1_reg[3][0]);
        for (int i = 0; i < 4; i++)
            oq[i] = round_quat(acc[i]);

        r_next[0][0] = 34'sd268435456 - ((ext(yy1_reg) + ext(zz1_reg)) <<< 1);
        r_next[0][1] = (ext(xy1_reg) - ext(wz1_reg)) <<< 1;
        r_next[0][2] = (ext(xz1_reg) + ext(wy1_reg)) <<< 1;
        r_next[1][0] = (ext(xy1_reg) + ext(wz1_reg)) <<< 1;
        r_next[1][1] = 34'sd268435456 - ((ext(xx1_reg) + ext(zz1_reg)) <<< 1);
        r_next[1][2] = (ext(yz1_reg) - ext(wx1_reg)) <<< 1;
        r_next[2][0] = (ext(xz1_reg) - ext(wy1_reg)) <<< 1;
        r_next[2][1] = (ext(yz1_reg) + ext(wx1_reg)) <<< 1;
        r_next[2][2] = 34'sd268435456 - ((ext(xx1_reg) + ext(yy1_reg)) <<< 1);

        gdtdt     = 61'(gdt1_reg) * 61'(dt1_reg);
        gdt2_next = 51'(((gdtdt >> 1) + 61'd512) >> 10);
    end

    logic [63:0]        o2_reg;
    logic               qsat2_reg;
    logic signed [33:0] r2_reg [3][3];
    logic        [50:0] gdt2_reg;
    logic        [40:0] gdt2g_reg;
    logic signed [41:0] vdt2_reg [3];
    logic signed [20:0] p2_reg [3], vel2_reg [3], al2_reg [3], be2_reg [3];

    always_ff @(posedge clk)
    begin
        o2_reg    <= {oq[0][15:0], oq[1][15:0], oq[2][15:0], oq[3][15:0]};
        qsat2_reg <= oq[0][16] | oq[1][16] | oq[2][16] | oq[3][16];
        r2_reg    <= r_next;
        gdt2_reg  <= gdt2_next;
        gdt2g_reg <= gdt1_reg;
        vdt2_reg  <= vdt1_reg;
        p2_reg    <= p1_reg;
        vel2_reg  <= vel1_reg;
        al2_reg   <= al1_reg;
        be2_reg   <= be1_reg;
    end

    // ------------------------------------------------------------------
    // Stage 3: rotation products and the base sums in Q38
    // ------------------------------------------------------------------
    logic signed [59:0] spb_next [3], svb_next [3];

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            spb_next[i] = (60'(p2_reg[i]) <<< 28) + (60'(vdt2_reg[i]) <<< 12);
            svb_next[i] = 60'(vel2_reg[i]) <<< 28;
        end
        // Drop gravity on z
        spb_next[2] = spb_next[2] - $signed(60'(gdt2_reg));
        svb_next[2] = svb_next[2] - ($signed(60'(gdt2g_reg)) <<< 6);
    end

    logic signed [54:0] ra3_reg [3][3], rb3_reg [3][3];
    logic signed [59:0] spb3_reg [3], svb3_reg [3];
    logic [63:0]        o3_reg;
    logic               qsat3_reg;

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
            begin
                ra3_reg[i][j] <= 55'(r2_reg[i][j]) * 55'(al2_reg[j]);
                rb3_reg[i][j] <= 55'(r2_reg[i][j]) * 55'(be2_reg[j]);
            end
        spb3_reg  <= spb_next;
        svb3_reg  <= svb_next;
        o3_reg    <= o2_reg;
        qsat3_reg <= qsat2_reg;
    end

    // ------------------------------------------------------------------
    // Stage 4: final sums, round, clip, pack
    // ------------------------------------------------------------------
    logic [21:0] np [3], nv [3];
    rsp_t        result_next;
    rsp_t        result_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            np[i] = round_vec(spb3_reg[i] + 60'(ra3_reg[i][0])
                              + 60'(ra3_reg[i][1]) + 60'(ra3_reg[i][2]));
            nv[i] = round_vec(svb3_reg[i] + 60'(rb3_reg[i][0])
                              + 60'(rb3_reg[i][1]) + 60'(rb3_reg[i][2]));
        end
        result_next.new_orientation = o3_reg;
        result_next.new_position    = {np[2][20:0], np[1][20:0], np[0][20:0]};
        result_next.new_velocity    = {nv[2][20:0], nv[1][20:0], nv[0][20:0]};
        result_next.saturated       = qsat3_reg | np[0][21] | np[1][21] | np[2][21]
                                    | nv[0][21] | nv[1][21] | nv[2][21];
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/imups_checker.sv]
// ============================================================================
// imups_checker: port-level checks for the state propagation block
// Latency and strobe checks seen from the top-level ports alone.
// ============================================================================
`default_nettype none

module imups_checker
    import imups_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic done
);

    // Every transfer gives a strobe after the pipeline depth
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("request transfer gave no result strobe");

    // No strobe without a transfer at the pipeline depth before it
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result strobe without a request transfer");

    // The block never holds requests off
    a_never_busy: assert property (@(posedge clk) !busy)
        else $error("busy raised");

    // No strobe while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !done)
        else $error("result strobe during reset");

endmodule

bind imu_preintegrated_state_propagate imups_checker u_imups_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done)
);

`default_nettype wire
